### rtl/amdq_pkg.sv
`default_nettype none

package amdq_pkg;

	localparam int unsigned COUNT_W = 25;
	localparam int unsigned SUM_W = 55;
	localparam int unsigned MONO_W = 16;
	localparam int unsigned OUT_DATA_W = 24;

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [15:0] RATE_MIN = 16'd8000;
	localparam logic [15:0] RATE_MAX = 16'd48000;
	localparam logic [1:0] CH_MONO = 2'd1;
	localparam logic [1:0] CH_STEREO = 2'd2;
	localparam logic [COUNT_W-1:0] MIN_INPUTS = 25'd1000;
	localparam logic [8:0] MAX_SECONDS_P1 = 9'd301;
	localparam logic [2:0] SHORT_NUM = 3'd7;
	localparam logic [4:0] CLIP_RATIO = 5'd20;

	localparam logic [15:0] RST_SAMPLE_RATE = 16'd16000;
	localparam logic [1:0] RST_CHANNEL_COUNT = 2'd1;
	localparam logic [19:0] RST_MIN_RMS_SQUARE = 20'd26844;
	localparam logic [14:0] RST_CLIP_LEVEL = 15'd32440;

	localparam logic KIND_MONO = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK,
		ST_RATE,
		ST_CHANNELS,
		ST_TOO_FEW,
		ST_TOO_LONG,
		ST_TOO_SHORT,
		ST_QUIET,
		ST_CLIPPING
	} status_t;

	typedef enum logic [1:0] {
		CFG_SAMPLE_RATE,
		CFG_CHANNEL_COUNT,
		CFG_MIN_RMS_SQUARE,
		CFG_CLIP_LEVEL
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] rate;
		logic [1:0] chans;
		logic [19:0] min_rms;
		logic [14:0] clip_lvl;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] inputs;
		logic [COUNT_W-1:0] monos;
		logic [SUM_W-1:0] sum;
		logic [COUNT_W-1:0] clips;
	} counts_t;

	typedef struct packed {
		logic kind;
		logic [MONO_W-1:0] mono;
		status_t status;
		logic fin;
	} result_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (&c) ? c : c + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

### rtl/amdq_downmix.sv
`default_nettype none

module amdq_downmix
	import amdq_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [1:0] chans,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input wire logic s_tlast,
	input wire logic room,
	input wire logic verdict_done,
	output logic valid_s1,
	output logic signed [SAMPLE_WIDTH-1:0] mono_s1,
	output logic have_s1,
	output logic last_s1
);

	logic busy_q;
	logic phase_q;
	logic signed [SAMPLE_WIDTH-1:0] held_q;
	logic signed [SAMPLE_WIDTH:0] pair_sum;
	logic stereo;
	logic accept;

	assign stereo = (chans == CH_STEREO);
	assign s_tready = !busy_q && room;
	assign accept = s_tvalid && s_tready;
	assign pair_sum = {held_q[SAMPLE_WIDTH-1], held_q} + {sample[SAMPLE_WIDTH-1], sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			held_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept && s_tlast) begin
				busy_q <= 1'b1;
			end else if (verdict_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				if (s_tlast) begin
					phase_q <= 1'b0;
					held_q <= '0;
				end else if (stereo) begin
					phase_q <= !phase_q;
					if (!phase_q) begin
						held_q <= sample;
					end
				end
			end
		end
	end

	// arithmetic shift of the pair sum floors toward minus infinity
	always_ff @(posedge clk) begin
		if (accept) begin
			mono_s1 <= stereo ? pair_sum[SAMPLE_WIDTH:1] : sample;
			have_s1 <= !stereo || phase_q;
			last_s1 <= s_tlast;
		end
	end

endmodule

`default_nettype wire

### rtl/amdq_stats.sv
`default_nettype none

module amdq_stats
	import amdq_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [14:0] clip_lvl,
	input wire logic valid_s1,
	input wire logic signed [SAMPLE_WIDTH-1:0] mono_s1,
	input wire logic have_s1,
	input wire logic last_s1,
	output logic valid_s2,
	output logic mono_push,
	output logic [MONO_W-1:0] mono_out,
	output logic snap_vld,
	output counts_t snap
);

	localparam int MAG_W = (SAMPLE_WIDTH > 15) ? SAMPLE_WIDTH : 15;
	localparam int EXT_W = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

	logic signed [SAMPLE_WIDTH-1:0] mono_s2;
	logic [2*SAMPLE_WIDTH-1:0] sq_s2;
	logic clipf_s2;
	logic have_s2;
	logic last_s2;
	counts_t cnt_q;
	counts_t nxt;
	logic [SAMPLE_WIDTH-1:0] mag;
	logic signed [2*SAMPLE_WIDTH-1:0] sq_d;
	logic [SUM_W:0] sum_ext;
	logic signed [EXT_W-1:0] mono_ext;

	// magnitude of the most negative value wraps to the right unsigned result
	assign mag = mono_s1[SAMPLE_WIDTH-1] ? (~mono_s1 + SAMPLE_WIDTH'(1)) : mono_s1;
	assign sq_d = mono_s1 * mono_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mono_s2 <= mono_s1;
			sq_s2 <= sq_d;
			clipf_s2 <= MAG_W'(mag) >= MAG_W'(clip_lvl);
			have_s2 <= have_s1;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		nxt = cnt_q;
		sum_ext = {1'b0, cnt_q.sum} + (SUM_W + 1)'(sq_s2);
		nxt.inputs = sat_inc(cnt_q.inputs);
		if (have_s2) begin
			nxt.monos = sat_inc(cnt_q.monos);
			nxt.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			if (clipf_s2) begin
				nxt.clips = sat_inc(cnt_q.clips);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (valid_s2) begin
			cnt_q <= last_s2 ? '0 : nxt;
		end
	end

	assign mono_ext = EXT_W'(mono_s2);
	assign mono_out = mono_ext[MONO_W-1:0];
	assign mono_push = valid_s2 && have_s2;
	assign snap_vld = valid_s2 && last_s2;
	assign snap = nxt;

endmodule

`default_nettype wire

### rtl/amdq_verdict.sv
`default_nettype none

module amdq_verdict
	import amdq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic snap_vld,
	input wire counts_t snap,
	input wire logic take,
	output logic vld_v3,
	output status_t status
);

	typedef struct packed {
		logic rate_bad;
		logic ch_bad;
		logic few;
		logic short_run;
		logic quiet;
		logic clipping;
	} flags_t;

	logic vld_v1;
	logic vld_v2;
	counts_t cnt_v1;
	counts_t cnt_v2;
	logic [17:0] rc_v2;
	logic [44:0] prod_v2;
	logic [18:0] r7_v2;
	logic [29:0] c20_v2;
	logic [26:0] thr_v3;
	logic [COUNT_W-1:0] in_v3;
	flags_t flags_v3;
	flags_t flags_d;
	logic long_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_v1 <= 1'b0;
			vld_v2 <= 1'b0;
			vld_v3 <= 1'b0;
		end else begin
			vld_v1 <= snap_vld;
			vld_v2 <= vld_v1;
			if (vld_v2) begin
				vld_v3 <= 1'b1;
			end else if (take) begin
				vld_v3 <= 1'b0;
			end
		end
	end

	always_comb begin
		flags_d.rate_bad = (cfg.rate < RATE_MIN) || (cfg.rate > RATE_MAX);
		flags_d.ch_bad = (cfg.chans != CH_MONO) && (cfg.chans != CH_STEREO);
		flags_d.few = cnt_v2.inputs < MIN_INPUTS;
		flags_d.short_run = {cnt_v2.monos, 1'b0} < 26'(r7_v2);
		flags_d.quiet = cnt_v2.sum < SUM_W'(prod_v2);
		flags_d.clipping = c20_v2 > 30'(cnt_v2.monos);
	end

	always_ff @(posedge clk) begin
		if (snap_vld) begin
			cnt_v1 <= snap;
		end
		if (vld_v1) begin
			cnt_v2 <= cnt_v1;
			rc_v2 <= 18'(cfg.rate) * 18'(cfg.chans);
			prod_v2 <= 45'(cfg.min_rms) * 45'(cnt_v1.monos);
			r7_v2 <= 19'(cfg.rate) * 19'(SHORT_NUM);
			c20_v2 <= 30'(cnt_v1.clips) * 30'(CLIP_RATIO);
		end
		if (vld_v2) begin
			thr_v3 <= 27'(rc_v2) * 27'(MAX_SECONDS_P1);
			in_v3 <= cnt_v2.inputs;
			flags_v3 <= flags_d;
		end
	end

	// quotient above the limit is the same as count at or above limit plus one times divisor
	assign long_run = 27'(in_v3) >= thr_v3;

	always_comb begin
		priority if (flags_v3.rate_bad) begin
			status = ST_RATE;
		end else if (flags_v3.ch_bad) begin
			status = ST_CHANNELS;
		end else if (flags_v3.few) begin
			status = ST_TOO_FEW;
		end else if (long_run) begin
			status = ST_TOO_LONG;
		end else if (flags_v3.short_run) begin
			status = ST_TOO_SHORT;
		end else if (flags_v3.quiet) begin
			status = ST_QUIET;
		end else if (flags_v3.clipping) begin
			status = ST_CLIPPING;
		end else begin
			status = ST_OK;
		end
	end

endmodule

`default_nettype wire

### rtl/amdq_out_fifo.sv
`default_nettype none

module amdq_out_fifo
	import amdq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire result_t push_data,
	input wire logic pop,
	output result_t head,
	output logic [CNT_W-1:0] count
);

	result_t mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

`default_nettype wire

### rtl/audio_mono_downmix_quality_gate.sv
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_tvalid/s_tready  s_tdata: sample; s_tlast: last sample of recording
// m_        out        m_tvalid/m_tready  m_tdata: mono_sample, status; m_tuser: kind;
//                                         m_tlast: final_res
// cfg_      in         cfg_we             cfg_index, cfg_data
//
// one sample per cycle while s_tready is high; a request passes the s1 and s2 registers into the output queue
// the last sample of a recording blocks s_tready until its verdict enters the
// output queue, after passing the three-stage verdict multiply chain
// a four-entry output queue absorbs m_tready stalls; s_tready falls once queued
// and in-flight requests fill it
// arst_n clears counters, phase and queue and restores register defaults

module audio_mono_downmix_quality_gate
	import amdq_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// sample [SAMPLE_WIDTH-1:0], zero fill
	input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	input wire logic s_tlast,
	output logic m_tvalid,
	input wire logic m_tready,
	// mono_sample [15:0], status [18:16], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// kind
	output logic m_tuser,
	output logic m_tlast,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [19:0] cfg_data
);

	cfg_t cfg_q;
	logic room;
	logic verdict_take;
	logic valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] mono_s1;
	logic have_s1;
	logic last_s1;
	logic valid_s2;
	logic mono_push;
	logic [MONO_W-1:0] mono_out;
	logic snap_vld;
	counts_t snap;
	logic vld_v3;
	status_t v_status;
	logic push;
	result_t push_data;
	result_t head;
	logic [CNT_W-1:0] fifo_count;
	logic [CNT_W:0] inflight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate <= RST_SAMPLE_RATE;
			cfg_q.chans <= RST_CHANNEL_COUNT;
			cfg_q.min_rms <= RST_MIN_RMS_SQUARE;
			cfg_q.clip_lvl <= RST_CLIP_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SAMPLE_RATE: cfg_q.rate <= cfg_data[15:0];
				CFG_CHANNEL_COUNT: cfg_q.chans <= cfg_data[1:0];
				CFG_MIN_RMS_SQUARE: cfg_q.min_rms <= cfg_data;
				CFG_CLIP_LEVEL: cfg_q.clip_lvl <= cfg_data[14:0];
			endcase
		end
	end

	assign inflight = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(valid_s1)
		+ (CNT_W + 1)'(valid_s2);
	assign room = inflight < (CNT_W + 1)'(OUT_DEPTH);

	amdq_downmix #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_downmix (
		.clk(clk),
		.arst_n(arst_n),
		.chans(cfg_q.chans),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sample(s_tdata[SAMPLE_WIDTH-1:0]),
		.s_tlast(s_tlast),
		.room(room),
		.verdict_done(verdict_take),
		.valid_s1(valid_s1),
		.mono_s1(mono_s1),
		.have_s1(have_s1),
		.last_s1(last_s1)
	);

	amdq_stats #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.clip_lvl(cfg_q.clip_lvl),
		.valid_s1(valid_s1),
		.mono_s1(mono_s1),
		.have_s1(have_s1),
		.last_s1(last_s1),
		.valid_s2(valid_s2),
		.mono_push(mono_push),
		.mono_out(mono_out),
		.snap_vld(snap_vld),
		.snap(snap)
	);

	amdq_verdict u_verdict (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.snap_vld(snap_vld),
		.snap(snap),
		.take(verdict_take),
		.vld_v3(vld_v3),
		.status(v_status)
	);

	assign verdict_take = vld_v3 && !mono_push && (fifo_count != CNT_W'(OUT_DEPTH));
	assign push = mono_push || verdict_take;

	always_comb begin
		if (mono_push) begin
			push_data.kind = KIND_MONO;
			push_data.mono = mono_out;
			push_data.status = ST_OK;
			push_data.fin = 1'b0;
		end else begin
			push_data.kind = KIND_VERDICT;
			push_data.mono = '0;
			push_data.status = v_status;
			push_data.fin = 1'b1;
		end
	end

	amdq_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(m_tvalid && m_tready),
		.head(head),
		.count(fifo_count)
	);

	assign m_tvalid = (fifo_count != '0);
	assign m_tdata = {(OUT_DATA_W - MONO_W - 3)'(0), head.status, head.mono};
	assign m_tuser = head.kind;
	assign m_tlast = head.fin;

endmodule

`default_nettype wire

### bench/tb_audio_mono_downmix_quality_gate.sv
`timescale 1ns / 1ps

module tb_audio_mono_downmix_quality_gate;
	import amdq_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_CAP = 40;

	typedef struct {
		logic [15:0] smp;
		logic lst;
	} sample_req_t;

	typedef struct {
		logic kind;
		logic [15:0] mono;
		status_t status;
		logic fin;
	} downmix_out_t;

	typedef enum {MIX_FULL, MIX_QUIET, MIX_EDGES} content_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	audio_mono_downmix_quality_gate i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	sample_req_t samples_to_send[$];
	downmix_out_t due_results[$];
	int mismatches = 0;
	int inputs_taken = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit s_taken = 1'b0;

	// block model: registers and running statistics
	logic [15:0] cfg_rate = RST_SAMPLE_RATE;
	logic [1:0] cfg_chans = RST_CHANNEL_COUNT;
	logic [19:0] cfg_min_rms = RST_MIN_RMS_SQUARE;
	logic [14:0] cfg_clip = RST_CLIP_LEVEL;
	logic ch_phase = 1'b0;
	logic [15:0] held = '0;
	logic [24:0] in_cnt = '0;
	logic [24:0] mono_cnt = '0;
	logic [54:0] sq_sum = '0;
	logic [24:0] clip_cnt = '0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("%0t ns: %s", $time, msg);
	endtask

	function automatic logic [24:0] bump(input logic [24:0] c);
		return (c == '1) ? c : c + 25'd1;
	endfunction

	function automatic status_t grade();
		logic [63:0] rate, n_in, n_mono, n_clip;
		rate = 64'(cfg_rate);
		n_in = 64'(in_cnt);
		n_mono = 64'(mono_cnt);
		n_clip = 64'(clip_cnt);
		if (rate < 64'd8000 || rate > 64'd48000)
			return ST_RATE;
		if (cfg_chans != CH_MONO && cfg_chans != CH_STEREO)
			return ST_CHANNELS;
		if (n_in < 64'd1000)
			return ST_TOO_FEW;
		if (n_in / (rate * 64'(cfg_chans)) > 64'd300)
			return ST_TOO_LONG;
		if (64'd2 * n_mono < 64'd7 * rate)
			return ST_TOO_SHORT;
		if (64'(sq_sum) < 64'(cfg_min_rms) * n_mono)
			return ST_QUIET;
		if (64'd20 * n_clip > n_mono)
			return ST_CLIPPING;
		return ST_OK;
	endfunction

	task automatic downmix_and_grade(input logic [15:0] smp, input logic lst);
		logic signed [16:0] pair_sum;
		logic [15:0] mono;
		logic have_mono;
		logic [16:0] mag;
		logic [33:0] sq;
		logic [55:0] new_sum;
		have_mono = 1'b0;
		mono = '0;
		in_cnt = bump(in_cnt);
		if (cfg_chans == CH_STEREO) begin
			if (!ch_phase) begin
				held = smp;
				ch_phase = 1'b1;
			end else begin
				pair_sum = $signed({held[15], held}) + $signed({smp[15], smp});
				mono = pair_sum[16:1];
				ch_phase = 1'b0;
				have_mono = 1'b1;
			end
		end else begin
			mono = smp;
			have_mono = 1'b1;
		end
		if (have_mono) begin
			mag = mono[15] ? (17'd0 - {1'b1, mono}) : {1'b0, mono};
			sq = {17'd0, mag} * {17'd0, mag};
			mono_cnt = bump(mono_cnt);
			new_sum = {1'b0, sq_sum} + 56'(sq);
			sq_sum = new_sum[55] ? '1 : new_sum[54:0];
			if (mag >= {2'b00, cfg_clip})
				clip_cnt = bump(clip_cnt);
			due_results.push_back('{KIND_MONO, mono, ST_OK, 1'b0});
		end
		if (lst) begin
			due_results.push_back('{KIND_VERDICT, 16'd0, grade(), 1'b1});
			ch_phase = 1'b0;
			held = '0;
			in_cnt = '0;
			mono_cnt = '0;
			sq_sum = '0;
			clip_cnt = '0;
		end
	endtask

	always @(posedge clk) begin : watch
		downmix_out_t got, want;
		s_taken = s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SAMPLE_RATE: cfg_rate = cfg_data[15:0];
					CFG_CHANNEL_COUNT: cfg_chans = cfg_data[1:0];
					CFG_MIN_RMS_SQUARE: cfg_min_rms = cfg_data[19:0];
					CFG_CLIP_LEVEL: cfg_clip = cfg_data[14:0];
					default: ;
				endcase
			end
			if (s_taken) begin
				downmix_and_grade(s_tdata, s_tlast);
				inputs_taken++;
			end
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.mono = m_tdata[15:0];
				got.status = status_t'(m_tdata[18:16]);
				got.fin = m_tlast;
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing due: kind %0d mono %0d status %0d",
						got.kind, $signed(got.mono), got.status));
				end else begin
					want = due_results.pop_front();
					if (got.kind !== want.kind || got.mono !== want.mono ||
							got.status !== want.status || got.fin !== want.fin)
						report_mismatch($sformatf(
							"got kind %0d mono %0d status %0d last %0d, want %0d %0d %0d %0d",
							got.kind, $signed(got.mono), got.status, got.fin,
							want.kind, $signed(want.mono), want.status, want.fin));
				end
			end
		end
	end

	always @(negedge clk) begin : drive_samples
		sample_req_t nxt;
		if (!s_tvalid || s_taken) begin
			if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = samples_to_send.pop_front();
				s_tdata <= nxt.smp;
				s_tlast <= nxt.lst;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// one long output stall early on, so the input side backs up
	always @(negedge clk) begin : drive_ready
		if (!hold_done && inputs_taken >= 40) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_audio_mono_downmix_quality_gate: FAIL");
			$finish;
		end
	end

	task automatic queue_sample(input logic [15:0] smp, input logic lst);
		samples_to_send.push_back('{smp, lst});
	endtask

	task automatic queue_recording(input int len, input content_t mix);
		logic [15:0] v;
		for (int i = 0; i < len; i++) begin
			case (mix)
				MIX_QUIET: v = 16'($urandom_range(300) - 150);
				MIX_EDGES: begin
					case ($urandom_range(5))
						0: v = 16'h7fff;
						1: v = 16'h8000;
						2: v = 16'h0000;
						3: v = 16'hffff;
						4: v = 16'h0001;
						default: v = 16'($urandom);
					endcase
				end
				default: v = 16'($urandom);
			endcase
			queue_sample(v, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (samples_to_send.size() != 0 || s_tvalid || due_results.size() != 0);
	endtask

	task automatic settle();
		wait_drained();
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// unused upper bits of the write data carry noise
	task automatic configure(input logic [15:0] rate, input logic [1:0] chans,
			input logic [19:0] min_rms, input logic [14:0] clip);
		settle();
		write_reg(CFG_SAMPLE_RATE, {4'($urandom), rate});
		write_reg(CFG_CHANNEL_COUNT, {18'($urandom), chans});
		write_reg(CFG_MIN_RMS_SQUARE, min_rms);
		write_reg(CFG_CLIP_LEVEL, {5'($urandom), clip});
		@(posedge clk);
	endtask

	task automatic random_setup();
		logic [15:0] r;
		logic [1:0] c;
		logic [19:0] q;
		logic [14:0] k;
		case ($urandom_range(7))
			0: r = 16'd8000;
			1: r = 16'd48000;
			2: r = 16'd7999;
			3: r = 16'd48001;
			4: r = 16'($urandom);
			5: r = 16'd0;
			6: r = 16'hffff;
			default: r = 16'($urandom_range(48000, 8000));
		endcase
		if ($urandom_range(9) < 2)
			c = 2'($urandom);
		else
			c = $urandom_range(1) ? CH_STEREO : CH_MONO;
		case ($urandom_range(3))
			0: q = '0;
			1: q = '1;
			default: q = 20'($urandom);
		endcase
		case ($urandom_range(3))
			0: k = '0;
			1: k = '1;
			2: k = RST_CLIP_LEVEL;
			default: k = 15'($urandom);
		endcase
		configure(r, c, q, k);
	endtask

	initial begin
		int queued;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 20;
		rx_idle_pct = 59;

		// reset settings, mono passthrough
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'hffff, 1'b1);

		// stereo averaging, floor on odd sums, odd trailing sample
		configure(RST_SAMPLE_RATE, CH_STEREO, RST_MIN_RMS_SQUARE, RST_CLIP_LEVEL);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'hffff, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'h0000, 1'b0);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0005, 1'b1);
		// pair completed by the last sample: mono before verdict
		queue_sample(16'h0007, 1'b0);
		queue_sample(16'hfff8, 1'b1);

		// bad rate, bad channel counts
		configure(16'd7999, 2'd3, '1, '0);
		queue_sample(16'h0064, 1'b0);
		queue_sample(16'hff9c, 1'b1);
		configure(16'd48000, 2'd0, '0, '1);
		queue_sample(16'h04d2, 1'b0);
		queue_sample(16'hffff, 1'b1);
		configure(16'd48001, 2'd3, 20'd12345, 15'd100);
		queue_sample(16'h1234, 1'b0);
		queue_sample(16'h8000, 1'b1);

		for (int p = 0; p < 3; p++) begin
			settle();
			case (p)
				0: begin
					tx_idle_pct = 20;
					rx_idle_pct = 59;
				end
				1: begin
					tx_idle_pct = 59;
					rx_idle_pct = 20;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int b = 0; b < 6; b++) begin
				random_setup();
				queued = 0;
				if (p == 0 && b == 1) begin
					// sender stops mid-recording until all results are out
					for (int i = 0; i < 7; i++)
						queue_sample(16'($urandom), 1'b0);
					wait_drained();
					queue_recording(6, MIX_FULL);
					queued = 13;
				end
				while (queued < 20) begin
					int len;
					content_t mix;
					len = ($urandom_range(9) < 7) ? $urandom_range(16, 1) : $urandom_range(60, 17);
					case ($urandom_range(5))
						0: mix = MIX_QUIET;
						1, 2: mix = MIX_EDGES;
						default: mix = MIX_FULL;
					endcase
					queue_recording(len, mix);
					queued += len;
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("tb_audio_mono_downmix_quality_gate: PASS");
		else
			$display("tb_audio_mono_downmix_quality_gate: FAIL");
		$finish;
	end

endmodule
